// ===== rtl/core/msim_pkg.sv =====
`default_nettype none

package msim_pkg;

	// fixed field widths
	localparam int SEL_W  = 2;
	localparam int CAP_W  = 9;
	localparam int WORD_W = 32;

	// build defaults and reset value of the capacity register
	localparam int NUM_STACKS_DEF  = 3;
	localparam int STACK_DEPTH_DEF = 256;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

	// queue depths between the parts
	localparam int CMDQ_DEPTH = 2;
	localparam int OUTQ_DEPTH = 4;

	typedef enum logic {
		OP_PUSH = 1'b0,
		OP_POP  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_PUSH_FULL = 2'd1,
		ST_POP_EMPTY = 2'd2,
		ST_BAD_STACK = 2'd3
	} status_t;

	typedef struct packed {
		op_t                      operation;
		logic [SEL_W-1:0]         stack_select;
		logic signed [WORD_W-1:0] push_value;
	} in_word_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] pop_value;
		status_t                  status;
		logic                     stack_now_full;
		logic                     stack_now_empty;
	} out_word_t;

	// classified operation handed from front to back
	typedef struct packed {
		logic    wr;
		logic    rd;
		status_t status;
		logic    now_full;
		logic    now_empty;
	} cmd_info_t;

endpackage

`default_nettype wire

// ===== rtl/core/msim_ram.sv =====
`default_nettype none

module msim_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 768
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/msim_fifo.sv =====
`default_nettype none

module msim_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  full,
	output logic                  empty,
	output logic                  afull
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int LVL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		full    = level_q == LVL_W'(DEPTH);
		empty   = level_q == '0;
		afull   = level_q >= LVL_W'(DEPTH - 1);
		do_push = push && !full;
		do_pop  = pop && !empty;
		rdata   = mem_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				level_q <= level_q + LVL_W'(1);
			end else if (do_pop && !do_push) begin
				level_q <= level_q - LVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/msim_front.sv =====
`default_nettype none

module msim_front #(
	parameter int NUM_STACKS  = msim_pkg::NUM_STACKS_DEF,
	parameter int STACK_DEPTH = msim_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      push,
	input  wire msim_pkg::in_word_t                        item,
	input  wire logic                                      cfg_we,
	input  wire logic [msim_pkg::CAP_W-1:0]                cfg_data,
	input  wire logic                                      cmd_full,
	output logic                                           cmd_push,
	output msim_pkg::cmd_info_t                            cmd_info,
	output logic [$clog2(NUM_STACKS*STACK_DEPTH)-1:0]      cmd_addr,
	output logic [msim_pkg::WORD_W-1:0]                    cmd_wdata
);

	import msim_pkg::*;

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int XW = (CW > CAP_W) ? CW : CAP_W;
	localparam int SW = $clog2(NUM_STACKS);
	localparam int AW = $clog2(NUM_STACKS * STACK_DEPTH);
	localparam int PW = XW + SEL_W + 1;
	localparam logic [SEL_W:0]  NS      = (SEL_W + 1)'(NUM_STACKS);
	localparam logic [XW-1:0]   DEPTH_X = XW'(STACK_DEPTH);

	logic [CAP_W-1:0] cap_q;
	logic [CW-1:0]    cnt_q [NUM_STACKS];

	logic          accept;
	logic          bad;
	logic          is_pop;
	logic          ok;
	logic [SW-1:0] sel_idx;
	logic [CW-1:0] cnt;
	logic [CW-1:0] cnt_new;
	logic [XW-1:0] cnt_x;
	logic [XW-1:0] cap_x;
	logic [XW-1:0] cap_eff;
	logic [PW-1:0] base;
	logic [PW-1:0] addr_sum;

	always_comb begin
		accept  = push && !cmd_full;
		bad     = {1'b0, item.stack_select} >= NS;
		sel_idx = item.stack_select[SW-1:0];
		cnt     = bad ? '0 : cnt_q[sel_idx];
		cnt_x   = XW'(cnt);
		is_pop  = item.operation == OP_POP;

		// capacity clipped to 1..depth
		cap_x   = XW'(cap_q);
		cap_eff = (cap_x == '0) ? XW'(1) : cap_x;
		if (cap_eff > DEPTH_X) begin
			cap_eff = DEPTH_X;
		end

		if (is_pop) begin
			ok      = cnt != '0;
			cnt_new = ok ? cnt - CW'(1) : cnt;
		end else begin
			ok      = cnt_x < cap_eff;
			cnt_new = ok ? cnt + CW'(1) : cnt;
		end

		// slice base plus top, one lower for pop
		base     = PW'(item.stack_select) * PW'(cap_eff);
		addr_sum = base + PW'(cnt_x) - PW'(is_pop);

		cmd_push           = accept;
		cmd_addr           = addr_sum[AW-1:0];
		cmd_wdata          = item.push_value;
		cmd_info.wr        = !bad && !is_pop && ok;
		cmd_info.rd        = !bad && is_pop && ok;
		cmd_info.now_full  = !bad && (XW'(cnt_new) >= cap_eff);
		cmd_info.now_empty = !bad && (cnt_new == '0);
		if (bad) begin
			cmd_info.status = ST_BAD_STACK;
		end else if (!ok) begin
			cmd_info.status = is_pop ? ST_POP_EMPTY : ST_PUSH_FULL;
		end else begin
			cmd_info.status = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
			for (int i = 0; i < NUM_STACKS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (accept && !bad && ok) begin
				cnt_q[sel_idx] <= cnt_new;
			end
		end
	end

`ifndef SYNTH
	a_bad_no_effect: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && bad) |-> (!cmd_info.wr && !cmd_info.rd
			&& !cmd_info.now_full && !cmd_info.now_empty))
		else $error("bad stack number produced an access or flags");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd_info.wr && !cfg_we) |=> (cnt_q[$past(sel_idx)] == $past(cnt) + CW'(1)))
		else $error("accepted push did not grow the count");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/msim_back.sv =====
`default_nettype none

module msim_back #(
	parameter int NUM_STACKS  = msim_pkg::NUM_STACKS_DEF,
	parameter int STACK_DEPTH = msim_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                                      clk,
	input  wire logic                                      arst_n,
	input  wire logic                                      cmd_empty,
	input  wire msim_pkg::cmd_info_t                       cmd_info,
	input  wire logic [$clog2(NUM_STACKS*STACK_DEPTH)-1:0] cmd_addr,
	input  wire logic [msim_pkg::WORD_W-1:0]               cmd_wdata,
	output logic                                           cmd_pop,
	output msim_pkg::out_word_t                            result,
	output logic                                           empty,
	input  wire logic                                      pop
);

	import msim_pkg::*;

	localparam int OW = $bits(out_word_t);

	logic             valid_s1;
	cmd_info_t        info_s1;
	logic [WORD_W-1:0] rdata;
	out_word_t        res_word;
	logic [OW-1:0]    out_rdata;
	logic             out_full;
	logic             out_afull;

	// issue only with a free output slot for the word in flight
	always_comb begin
		cmd_pop = !cmd_empty && !out_full && !(valid_s1 && out_afull);
	end

	msim_ram #(
		.WIDTH(WORD_W),
		.DEPTH(NUM_STACKS * STACK_DEPTH)
	) u_store (
		.clk  (clk),
		.en   (cmd_pop && (cmd_info.wr || cmd_info.rd)),
		.we   (cmd_pop && cmd_info.wr),
		.addr (cmd_addr),
		.wdata(cmd_wdata),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_pop) begin
			info_s1 <= cmd_info;
		end
	end

	always_comb begin
		res_word.pop_value       = info_s1.rd ? rdata : '0;
		res_word.status          = info_s1.status;
		res_word.stack_now_full  = info_s1.now_full;
		res_word.stack_now_empty = info_s1.now_empty;
	end

	msim_fifo #(
		.WIDTH(OW),
		.DEPTH(OUTQ_DEPTH)
	) u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (valid_s1),
		.wdata (res_word),
		.pop   (pop),
		.rdata (out_rdata),
		.full  (out_full),
		.empty (empty),
		.afull (out_afull)
	);

	assign result = out_word_t'(out_rdata);

`ifndef SYNTH
	a_no_out_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !out_full)
		else $error("result queue written while full");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_empty |-> !(cmd_info.wr && cmd_info.rd))
		else $error("command asks for read and write at once");

	a_read_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_pop && cmd_info.rd) |=> (valid_s1 && info_s1.status == ST_OK))
		else $error("memory read for a failed pop");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/multi_stack_in_one_memory_top.sv =====
`default_nettype none

// path: a word goes through the command queue, the store read and the result queue
// throughput: one word per cycle while results are popped, set by the single port
//   of the shared store (one access per word) and the credit check on the result queue
// reset: counts cleared, capacity register 256, both queues empty; no clearing pass,
//   store contents stay undefined until written

module multi_stack_in_one_memory_top #(
	parameter int NUM_STACKS  = msim_pkg::NUM_STACKS_DEF,
	parameter int STACK_DEPTH = msim_pkg::STACK_DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// input side
	input  wire logic                       push,
	output logic                            full,
	input  wire msim_pkg::in_word_t         item,
	// result side
	output logic                            empty,
	input  wire logic                       pop,
	output msim_pkg::out_word_t             result,
	// capacity register
	input  wire logic                       cfg_we,
	input  wire logic [msim_pkg::CAP_W-1:0] cfg_data
);

	import msim_pkg::*;

	localparam int AW  = $clog2(NUM_STACKS * STACK_DEPTH);
	localparam int CMW = $bits(cmd_info_t) + AW + WORD_W;

	// front side of the command queue
	logic              f_push;
	cmd_info_t         f_info;
	logic [AW-1:0]     f_addr;
	logic [WORD_W-1:0] f_wdata;
	logic              cmd_full;

	// back side of the command queue
	logic [CMW-1:0]    cmd_rdata;
	logic              cmd_empty;
	logic              cmd_pop;
	cmd_info_t         b_info;
	logic [AW-1:0]     b_addr;
	logic [WORD_W-1:0] b_wdata;

	// front: capacity clip, count check, slice address, count update
	msim_front #(
		.NUM_STACKS (NUM_STACKS),
		.STACK_DEPTH(STACK_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.cmd_full (cmd_full),
		.cmd_push (f_push),
		.cmd_info (f_info),
		.cmd_addr (f_addr),
		.cmd_wdata(f_wdata)
	);

	// short command queue so front and back stall on their own
	msim_fifo #(
		.WIDTH(CMW),
		.DEPTH(CMDQ_DEPTH)
	) u_cmdq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (f_push),
		.wdata ({f_info, f_addr, f_wdata}),
		.pop   (cmd_pop),
		.rdata (cmd_rdata),
		.full  (cmd_full),
		.empty (cmd_empty),
		.afull ()
	);

	assign {b_info, b_addr, b_wdata} = cmd_rdata;

	// input is held off only by a full command queue
	assign full = cmd_full;

	// back: store access and result queue
	msim_back #(
		.NUM_STACKS (NUM_STACKS),
		.STACK_DEPTH(STACK_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_empty(cmd_empty),
		.cmd_info (b_info),
		.cmd_addr (b_addr),
		.cmd_wdata(b_wdata),
		.cmd_pop  (cmd_pop),
		.result   (result),
		.empty    (empty),
		.pop      (pop)
	);

endmodule

`default_nettype wire

// ===== test/tb_multi_stack_in_one_memory_top.sv =====
`default_nettype none

module tb_multi_stack_in_one_memory_top;
	import msim_pkg::*;

	localparam int NUM_STACKS  = NUM_STACKS_DEF;
	localparam int STACK_DEPTH = STACK_DEPTH_DEF;
	localparam int STORE_WORDS = NUM_STACKS * STACK_DEPTH;
	localparam int CYCLE_LIMIT = 300000;

	// one row of the directed plan: either a capacity write or one input word
	typedef struct packed {
		logic             is_cfg;
		logic [CAP_W-1:0] cap;
		in_word_t         w;
		logic             typed;
		out_word_t        want;
	} plan_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic             full;
	in_word_t         item = '0;
	logic             empty;
	logic             pop = 1'b0;
	out_word_t        result;
	logic             cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_data = '0;

	// predictor state: shared store, per-stack counts, capacity register
	logic [WORD_W-1:0] stack_mem [STORE_WORDS];
	bit                stack_mem_valid [STORE_WORDS];
	int unsigned       stack_cnt [NUM_STACKS];
	logic [CAP_W-1:0]  cap_reg = CAP_RESET;

	// expected result words, oldest first
	out_word_t pending_results[$];

	int errors = 0;
	int results_seen = 0;
	int cycle_cnt = 0;

	multi_stack_in_one_memory_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always #5 clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// register value 0 behaves as 1, anything above the built depth as the depth
	function automatic int unsigned eff_cap();
		int unsigned c;
		c = cap_reg;
		if (c == 0)
			c = 1;
		if (c > STACK_DEPTH)
			c = STACK_DEPTH;
		return c;
	endfunction

	// apply one word to the predicted stacks and return the result word it gives
	function automatic out_word_t stack_apply(in_word_t w);
		out_word_t   r;
		int unsigned cap;
		int unsigned base;
		int unsigned cnt;
		int unsigned addr;
		r = '0;
		r.status = ST_OK;
		cap = eff_cap();
		if (w.stack_select >= NUM_STACKS) begin
			r.status = ST_BAD_STACK;
		end else begin
			base = w.stack_select * cap;
			cnt = stack_cnt[w.stack_select];
			if (w.operation == OP_PUSH) begin
				if (cnt >= cap) begin
					r.status = ST_PUSH_FULL;
				end else begin
					addr = base + cnt;
					if (addr < STORE_WORDS) begin
						stack_mem[addr] = w.push_value;
						stack_mem_valid[addr] = 1'b1;
					end
					stack_cnt[w.stack_select] = cnt + 1;
				end
			end else if (cnt == 0) begin
				r.status = ST_POP_EMPTY;
			end else begin
				addr = base + cnt - 1;
				if (addr < STORE_WORDS)
					r.pop_value = stack_mem[addr];
				stack_cnt[w.stack_select] = cnt - 1;
			end
			r.stack_now_full = (stack_cnt[w.stack_select] >= cap);
			r.stack_now_empty = (stack_cnt[w.stack_select] == 0);
		end
		return r;
	endfunction

	// a pop must never read a slot that was never written
	function automatic bit pop_reads_written(logic [SEL_W-1:0] sel);
		int unsigned cnt;
		int unsigned addr;
		if (sel >= NUM_STACKS)
			return 1'b1;
		cnt = stack_cnt[sel];
		if (cnt == 0)
			return 1'b1;
		addr = sel * eff_cap() + cnt - 1;
		return (addr < STORE_WORDS) && stack_mem_valid[addr];
	endfunction

	// no random idling inside this window
	function automatic bit may_idle();
		return !(cycle_cnt >= 300 && cycle_cnt < 800);
	endfunction

	function automatic plan_row_t cap_row(logic [CAP_W-1:0] v);
		plan_row_t r;
		r = '0;
		r.is_cfg = 1'b1;
		r.cap = v;
		return r;
	endfunction

	function automatic plan_row_t op_row(op_t op, logic [SEL_W-1:0] sel, logic [WORD_W-1:0] v);
		plan_row_t r;
		r = '0;
		r.w.operation = op;
		r.w.stack_select = sel;
		r.w.push_value = v;
		return r;
	endfunction

	function automatic plan_row_t op_row_chk(op_t op, logic [SEL_W-1:0] sel,
		logic [WORD_W-1:0] v, logic [WORD_W-1:0] pv, status_t st, logic f, logic e);
		plan_row_t r;
		r = op_row(op, sel, v);
		r.typed = 1'b1;
		r.want.pop_value = pv;
		r.want.status = st;
		r.want.stack_now_full = f;
		r.want.stack_now_empty = e;
		return r;
	endfunction

	function automatic in_word_t random_word(logic [SEL_W-1:0] focus, bit focused, int p_push);
		in_word_t w;
		int roll;
		roll = $urandom_range(99);
		if (roll < 8)
			w.stack_select = 2'd3;
		else if (focused && roll < 90)
			w.stack_select = focus;
		else
			w.stack_select = SEL_W'($urandom_range(NUM_STACKS - 1));
		w.operation = ($urandom_range(99) < p_push) ? OP_PUSH : OP_POP;
		if (w.operation == OP_POP && !pop_reads_written(w.stack_select))
			w.operation = OP_PUSH;
		case ($urandom_range(9))
			0: w.push_value = 32'h8000_0000;
			1: w.push_value = 32'h7fff_ffff;
			2: w.push_value = '0;
			3: w.push_value = '1;
			default: w.push_value = $urandom;
		endcase
		return w;
	endfunction

	// offer one word until taken; push stays high afterwards
	task automatic send_word(in_word_t w, out_word_t want);
		while (may_idle() && $urandom_range(99) < 16) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do
			@(posedge clk);
		while (full !== 1'b0);
		pending_results.push_back(want);
	endtask

	// stop offering and wait until every expected word has come back
	task automatic settle();
		push <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_capacity(logic [CAP_W-1:0] v);
		settle();
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		cap_reg = v;
	endtask

	task automatic check_word(out_word_t want, out_word_t got);
		if (got.pop_value !== want.pop_value) begin
			$error("pop_value: expected %0d, got %0d", want.pop_value, got.pop_value);
			errors++;
		end
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			errors++;
		end
		if (got.stack_now_full !== want.stack_now_full) begin
			$error("stack_now_full: expected %0d, got %0d", want.stack_now_full,
				got.stack_now_full);
			errors++;
		end
		if (got.stack_now_empty !== want.stack_now_empty) begin
			$error("stack_now_empty: expected %0d, got %0d", want.stack_now_empty,
				got.stack_now_empty);
			errors++;
		end
	endtask

	// result side: checks each taken word, idles at random, and holds off
	// twice for a long stretch so the block backs up and raises full
	initial begin : result_side
		int hold_left;
		out_word_t want;
		hold_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && empty === 1'b0) begin
				if (pending_results.size() == 0) begin
					$error("result word with nothing expected");
					errors++;
				end else begin
					want = pending_results.pop_front();
					check_word(want, result);
				end
				results_seen++;
				if (results_seen == 150 || results_seen == 700)
					hold_left = 60;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= !(may_idle() && $urandom_range(99) < 16);
			end
		end
	end

	// input side: directed plan, then random phases at several capacities
	initial begin : input_side
		plan_row_t plan[$];
		out_word_t predicted;
		in_word_t w;
		int phase_caps [12];
		int n;
		int p_push;
		logic [SEL_W-1:0] focus;

		// empty, bad stack, extreme words, order of pops
		plan.push_back(op_row_chk(OP_POP, 2'd0, 32'h0, 32'h0, ST_POP_EMPTY, 1'b0, 1'b1));
		plan.push_back(op_row_chk(OP_PUSH, 2'd3, 32'h1234_5678, 32'h0, ST_BAD_STACK,
			1'b0, 1'b0));
		plan.push_back(op_row_chk(OP_POP, 2'd3, 32'h0, 32'h0, ST_BAD_STACK, 1'b0, 1'b0));
		plan.push_back(op_row_chk(OP_PUSH, 2'd0, 32'h7fff_ffff, 32'h0, ST_OK, 1'b0, 1'b0));
		plan.push_back(op_row_chk(OP_PUSH, 2'd0, 32'h8000_0000, 32'h0, ST_OK, 1'b0, 1'b0));
		plan.push_back(op_row(OP_PUSH, 2'd1, 32'h0));
		plan.push_back(op_row(OP_PUSH, 2'd2, 32'hffff_ffff));
		plan.push_back(op_row(OP_PUSH, 2'd2, 32'h5a5a_a5a5));
		plan.push_back(op_row_chk(OP_POP, 2'd0, 32'h0, 32'h8000_0000, ST_OK, 1'b0, 1'b0));
		plan.push_back(op_row_chk(OP_POP, 2'd0, 32'h0, 32'h7fff_ffff, ST_OK, 1'b0, 1'b1));
		plan.push_back(op_row(OP_POP, 2'd2, 32'h0));
		plan.push_back(op_row(OP_POP, 2'd2, 32'h0));
		plan.push_back(op_row(OP_POP, 2'd1, 32'h0));
		// capacity one: full after a single push, push on full
		plan.push_back(cap_row(9'd1));
		plan.push_back(op_row_chk(OP_PUSH, 2'd0, 32'haaaa_aaaa, 32'h0, ST_OK, 1'b1, 1'b0));
		plan.push_back(op_row_chk(OP_PUSH, 2'd0, 32'h1, 32'h0, ST_PUSH_FULL, 1'b1, 1'b0));
		plan.push_back(op_row_chk(OP_PUSH, 2'd2, 32'h5555_5555, 32'h0, ST_OK, 1'b1, 1'b0));
		plan.push_back(op_row_chk(OP_POP, 2'd0, 32'h0, 32'haaaa_aaaa, ST_OK, 1'b0, 1'b1));
		// register zero acts as capacity one
		plan.push_back(cap_row(9'd0));
		plan.push_back(op_row_chk(OP_PUSH, 2'd1, 32'h7, 32'h0, ST_OK, 1'b1, 1'b0));
		plan.push_back(op_row_chk(OP_POP, 2'd1, 32'h0, 32'h7, ST_OK, 1'b0, 1'b1));
		// register above the depth acts as the depth; stack 2 keeps its count
		plan.push_back(cap_row(9'd511));
		plan.push_back(op_row(OP_PUSH, 2'd0, 32'hffff_fffe));
		plan.push_back(op_row(OP_PUSH, 2'd2, 32'h3));
		plan.push_back(op_row(OP_POP, 2'd2, 32'h0));

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				set_capacity(plan[i].cap);
			end else begin
				predicted = stack_apply(plan[i].w);
				send_word(plan[i].w, plan[i].typed ? plan[i].want : predicted);
			end
		end

		// counts carry over between phases, so shrinking the capacity
		// leaves stacks at or above full
		phase_caps = '{2, 256, 1, 3, 0, 511, 7, 16, 255, 4, 100, 5};
		foreach (phase_caps[i]) begin
			set_capacity(CAP_W'(phase_caps[i]));
			focus = SEL_W'($urandom_range(NUM_STACKS - 1));
			if (phase_caps[i] == 256) begin
				// long push-heavy run that fills one stack to the depth
				n = 400;
				p_push = 92;
			end else begin
				n = 55;
				p_push = $urandom_range(35, 75);
			end
			repeat (n) begin
				w = random_word(focus, phase_caps[i] == 256 || $urandom_range(1) == 1, p_push);
				send_word(w, stack_apply(w));
			end
		end

		settle();
		repeat (6) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/core/msim_pkg.sv
rtl/core/msim_ram.sv
rtl/core/msim_fifo.sv
rtl/core/msim_front.sv
rtl/core/msim_back.sv
rtl/core/multi_stack_in_one_memory_top.sv
test/tb_multi_stack_in_one_memory_top.sv
